// ===== design/aes128_block_encrypt_assert.svh =====
// assertion macros for the aes128 block encryptor
`ifndef AES128_BLOCK_ENCRYPT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_ASSERT_SVH
// implication checked at every clock edge outside reset
`define AES_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication
`define AES_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ===== design/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// shared types and functions for the aes128 block encryptor
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;
   localparam int unsigned BLOCK_BITS = 128;
   localparam logic MODE_KEY = 1'b0;
   localparam logic MODE_ENC = 1'b1;

   typedef logic [BLOCK_BITS-1:0] block_type;

   typedef struct packed {
      logic valid;
      logic hold;
   } stage_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // byte n sits in bits 127-8n .. 120-8n
   function automatic logic [7:0] get_byte(input block_type b, input int unsigned n);
      get_byte = b[BLOCK_BITS-1-8*n -: 8];
   endfunction

   // multiply by x modulo 0x11b
   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[BLOCK_BITS-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
         end
      end
      sub_shift = t;
   endfunction

   function automatic block_type mix(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         t[BLOCK_BITS-1-8*(4*c) -: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[BLOCK_BITS-1-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[BLOCK_BITS-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[BLOCK_BITS-1-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      mix = t;
   endfunction
endpackage
`default_nettype wire

// ===== design/aes_round_cell.sv =====
// ----------------------------------------------------------------------------
// aes_round_cell
// one round of the pipeline: optional sbox/shift/mix, then key add, registered
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round_cell import aes_pkg::*; #(
   parameter bit DO_SUB = 1'b1,
   parameter bit DO_MIX = 1'b1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_ctl_type ctl_in,
   input  wire block_type     state_in,
   input  wire block_type     round_key,
   output logic               valid_out,
   output block_type          state_out
);
   logic      valid_ff, valid_in;
   block_type state_ff, state_in_next;
   block_type sub_v, mix_v;

   always_comb begin
      sub_v = DO_SUB ? sub_shift(state_in) : state_in;
      mix_v = DO_MIX ? mix(sub_v) : sub_v;
      valid_in      = ctl_in.hold ? valid_ff : ctl_in.valid;
      state_in_next = ctl_in.hold ? state_ff : (mix_v ^ round_key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      state_ff <= state_in_next;
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
endmodule
`default_nettype wire

// ===== design/aes128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// aes encryptor, ecb, with expanded round keys loaded by key-write beats
// ----------------------------------------------------------------------------
// an accepted beat passes through the registered round cells in order to the result beat
// throughput: one block per cycle while the result beat is taken, set by one round cell per round
// the whole cell chain stalls together when the result beat is not taken
// a key-write beat waits until every round cell is empty, so keys change between blocks
// reset clears valid flags only; the round-key store is undefined until written
`default_nettype none
module aes128_block_encrypt import aes_pkg::*; #(
   parameter int unsigned ROUND_COUNT = 10
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic         req_tuser,   // mode
   input  wire logic [167:0] req_tdata,   // key_index[5:0], key_word[37:6],
                                          // plain_high[101:38], plain_low[165:102]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata    // cipher_high[63:0], cipher_low[127:64]
);
   localparam int unsigned KEY_WORDS = 4 * (ROUND_COUNT + 1);
   localparam int unsigned STAGES = ROUND_COUNT + 1;

   logic [31:0] key_store [KEY_WORDS];
   logic [5:0]  key_index;
   logic        hold;
   logic        busy;
   logic        fire;

   logic      vld [STAGES+1];
   block_type st  [STAGES+1];

   // any block still inside the chain
   always_comb begin
      busy = 1'b0;
      for (int i = 1; i <= STAGES; i++) begin
         busy = busy | vld[i];
      end
   end

   assign key_index = req_tdata[5:0];
   assign hold = vld[STAGES] && !rsp_tready;
   assign req_tready = !hold && !(req_tuser == MODE_KEY && busy);
   assign fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (fire && req_tuser == MODE_KEY && 32'(key_index) < KEY_WORDS) begin
         key_store[key_index] <= req_tdata[37:6];
      end
   end

   assign vld[0] = fire && req_tuser == MODE_ENC;
   assign st[0]  = {req_tdata[101:38], req_tdata[165:102]};

   for (genvar r = 0; r < STAGES; r++) begin : g_round
      stage_ctl_type ctl;
      block_type     rk;
      assign ctl.valid = vld[r];
      assign ctl.hold  = hold;
      assign rk = {key_store[4*r], key_store[4*r+1], key_store[4*r+2], key_store[4*r+3]};
      aes_round_cell #(
         .DO_SUB(r != 0),
         .DO_MIX(r != 0 && r != STAGES-1)
      ) u_cell (
         .clock(clock), .reset(reset), .ctl_in(ctl), .state_in(st[r]),
         .round_key(rk), .valid_out(vld[r+1]), .state_out(st[r+1])
      );
   end

   assign rsp_tvalid = vld[STAGES];
   assign rsp_tdata  = {st[STAGES][63:0], st[STAGES][127:64]};
endmodule
`default_nettype wire

// ===== design/aes_port_checker.sv =====
// ----------------------------------------------------------------------------
// aes_port_checker
// port-level checks for the aes128 block encryptor, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "aes128_block_encrypt_assert.svh"
module aes_port_checker import aes_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata
);
   `AES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `AES_ASSERT_NEXT(a_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `AES_ASSERT_IMPL(a_ready_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `AES_ASSERT_IMPL(a_ready_free, clock, reset, !rsp_tvalid && req_tuser == MODE_ENC, req_tready)
   `AES_ASSERT_IMPL(a_key_idle, clock, reset,
      req_tvalid && req_tready && req_tuser == MODE_KEY, !rsp_tvalid)
endmodule

bind aes128_block_encrypt aes_port_checker u_port_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
`default_nettype wire
